FILE: design/sle_pkg.sv
// Shared types, constants and address helpers for the sorted list engine.
// Used by the sequencer, the top level and the port checker.
package sle_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] FN_INSERT     = 3'd0;
    localparam logic [2:0] FN_POP_FRONT  = 3'd1;
    localparam logic [2:0] FN_POP_BACK   = 3'd2;
    localparam logic [2:0] FN_READ_RANK  = 3'd3;
    localparam logic [2:0] FN_CLEAR      = 3'd4;

    typedef struct packed {
        logic        [2:0]  func;
        logic signed [31:0] value_in;
        logic        [5:0]  rank_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic               ok;
        logic        [6:0]  elem_count;
    } t_out_item;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [31:0]   wr_data;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
    } t_mem_req;

    // Map a rank to a RAM slot: the list is a ring that starts at head.
    function automatic logic [AW-1:0] phys_addr(logic [AW-1:0] head, logic [CW-1:0] rank);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(rank);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    function automatic logic [AW-1:0] next_slot(logic [AW-1:0] slot);
        logic [AW-1:0] nxt;
        if (slot == AW'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = slot + AW'(1);
        end
        return nxt;
    endfunction

endpackage

FILE: design/sle_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/sle_seq.sv
// Operation sequencer: keeps head and count, drives the list RAM, shifts entries on insert.
// Depends on sle_pkg.
module sle_seq
    import sle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_busy,
    output t_mem_req    o_mem,
    input  logic [31:0] i_rd_data,
    output logic        o_res_valid,
    output t_out_item   o_res,
    input  logic        i_res_free
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;
    logic signed [31:0] r_v, n_v;
    t_out_item          r_res, n_res;
    logic               gt;

    assign gt = $signed(i_rd_data) > r_v;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_k     = r_k;
        n_v     = r_v;
        n_res   = r_res;
        o_mem   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state         = S_DONE;
                    n_res.value_out = '0;
                    n_res.ok        = 1'b0;
                    n_res.elem_count = 7'(r_count);
                    case (i_in_item.func)
                        FN_INSERT: begin
                            if (32'(r_count) >= DEPTH) begin
                                n_state = S_DONE;
                            end else if (r_count == '0) begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = phys_addr(r_head, '0);
                                o_mem.wr_data = i_in_item.value_in;
                                n_count       = r_count + CW'(1);
                                n_res.ok      = 1'b1;
                                n_res.elem_count = 7'(r_count + CW'(1));
                            end else begin
                                // walk down from the largest entry
                                n_k           = r_count - CW'(1);
                                n_v           = i_in_item.value_in;
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = phys_addr(r_head, r_count - CW'(1));
                                n_state       = S_SCAN;
                            end
                        end
                        FN_POP_FRONT: begin
                            if (r_count != '0) begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = r_head;
                                n_head        = next_slot(r_head);
                                n_count       = r_count - CW'(1);
                                n_res.ok      = 1'b1;
                                n_res.elem_count = 7'(r_count - CW'(1));
                                n_state       = S_READ;
                            end
                        end
                        FN_POP_BACK: begin
                            if (r_count != '0) begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = phys_addr(r_head, r_count - CW'(1));
                                n_count       = r_count - CW'(1);
                                n_res.ok      = 1'b1;
                                n_res.elem_count = 7'(r_count - CW'(1));
                                n_state       = S_READ;
                            end
                        end
                        FN_READ_RANK: begin
                            if (32'(i_in_item.rank_index) < 32'(r_count)) begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = phys_addr(r_head, CW'(i_in_item.rank_index));
                                n_res.ok      = 1'b1;
                                n_state       = S_READ;
                            end
                        end
                        FN_CLEAR: begin
                            n_count          = '0;
                            n_res.ok         = 1'b1;
                            n_res.elem_count = '0;
                        end
                        default: begin
                            n_res.ok = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res.value_out = i_rd_data;
                n_state         = S_DONE;
            end
            S_SCAN: begin
                // shift a larger entry up one rank, or drop the new value in above one that is not larger
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = phys_addr(r_head, r_k + CW'(1));
                o_mem.wr_data = gt ? i_rd_data : r_v;
                if (gt) begin
                    if (r_k == '0) begin
                        n_state = S_LAST;
                    end else begin
                        n_k           = r_k - CW'(1);
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = phys_addr(r_head, r_k - CW'(1));
                    end
                end else begin
                    n_count          = r_count + CW'(1);
                    n_res.ok         = 1'b1;
                    n_res.elem_count = 7'(r_count + CW'(1));
                    n_state          = S_DONE;
                end
            end
            S_LAST: begin
                o_mem.wr_en      = 1'b1;
                o_mem.wr_addr    = r_head;
                o_mem.wr_data    = r_v;
                n_count          = r_count + CW'(1);
                n_res.ok         = 1'b1;
                n_res.elem_count = 7'(r_count + CW'(1));
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_k   <= n_k;
        r_v   <= n_v;
        r_res <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

FILE: design/sorted_list_engine_core.sv
// Sorted list engine top level: list RAM, operation sequencer and output register.
// Depends on sle_pkg, sle_ram and sle_seq.
//
// Holds up to DEPTH signed 32-bit values in ascending order in one RAM used as a
// ring, so remove-smallest only moves the head pointer. One operation is handled
// at a time. Clear, a failed operation or an insert into an empty list go
// straight from input transfer to result; remove-smallest, remove-largest and
// read at rank first pass through a RAM read state; an insert scans down from
// the largest, and the single RAM write port shifts each stored value greater
// than the new one up one rank per cycle, then writes the new value. The result
// sits in an output register, so a new input transfer is taken while it waits.
module sorted_list_engine_core
    import sle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_mem_req    mem;
    logic [31:0] rd_data;
    logic        busy;
    logic        res_valid;
    t_out_item   res;
    logic        res_free;
    logic        r_out_valid;
    t_out_item   r_out;

    sle_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (mem.wr_en),
        .i_wr_addr(mem.wr_addr),
        .i_wr_data(mem.wr_data),
        .i_rd_en  (mem.rd_en),
        .i_rd_addr(mem.rd_addr),
        .o_rd_data(rd_data)
    );

    sle_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_busy     (busy),
        .o_mem      (mem),
        .i_rd_data  (rd_data),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_free (res_free)
    );

    assign res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_free) begin
            r_out <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: design/sle_checker.sv
// Port-level checker for the sorted list engine, bound to the top level.
// Depends on sle_pkg.
module sle_checker
    import sle_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a stalled input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input changed");

    // one operation in flight: the cycle after a transfer is never another transfer
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an operation is in flight");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.ok |-> o_out_item.value_out == '0)
        else $error("failed result carries a value");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_item.elem_count) <= DEPTH)
        else $error("element count beyond capacity");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
